// ===== design/chvg_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the clock hand vertex generator.
package chvg_pkg;

  localparam int ANGLE_STEPS    = 720;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int QTR_STEPS      = ANGLE_STEPS / 4;

  localparam int ANGLE_W  = 10;
  localparam int LEN_W    = 11;
  localparam int WID_W    = 8;
  localparam int CTR_W    = 11;
  localparam int PX_W     = 13;
  localparam int QIDX_W   = $clog2(QTR_STEPS + 1);
  localparam int TBL_W    = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W   = TRIG_FRAC_BITS + 2;
  localparam int PROD_W   = LEN_W + 1 + TRIG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int MAG_W    = SUM_W - TRIG_FRAC_BITS;
  localparam int COORD_W  = MAG_W + 1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam int MAX_VERTS = 6;
  localparam int VIDX_W    = $clog2(MAX_VERTS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // shape codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRI     = 2'd1;
  localparam logic [1:0] OP_DIAMOND = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic [1:0]               op;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic [LEN_W-1:0]         len;
    logic [LEN_W-1:0]         off;
    logic [LEN_W-1:0]         inner;
    logic [LEN_W-1:0]         mid;
    logic [WID_W-1:0]         wid;
  } job_t;

  // elaboration-time series evaluation for the table
  localparam int          WORK_BITS    = 40;
  localparam int          HALF_WORK    = WORK_BITS / 2;
  localparam int          SERIES_TERMS = 12;
  localparam logic [63:0] WORK_ONE     = 64'd1 << WORK_BITS;
  localparam logic [63:0] HALF_PI_WORK = 64'd1727108826179;
  localparam logic [63:0] TRIG_DEN     = 64'(4 * ANGLE_STEPS);
  localparam logic [63:0] TRIG_ONE     = 64'd1 << TRIG_FRAC_BITS;
  localparam logic [63:0] WORK_HALF    = 64'd1 << (WORK_BITS - TRIG_FRAC_BITS - 1);
  localparam logic [63:0] HALF_MASK    = (64'd1 << HALF_WORK) - 64'd1;

  function automatic logic [63:0] mul_work(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl;
    ah = a >> HALF_WORK;
    al = a & HALF_MASK;
    bh = b >> HALF_WORK;
    bl = b & HALF_MASK;
    return ah * bh + ((ah * bl + al * bh) >> HALF_WORK) + ((al * bl) >> WORK_BITS);
  endfunction

  // shift-subtract quotient, only evaluated while the table is built
  function automatic logic [63:0] quot_work(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // magnitude of sin over a quarter turn, rounded half away from zero
  function automatic logic [(QTR_STEPS+1)*TBL_W-1:0] build_sin_tbl();
    logic [(QTR_STEPS+1)*TBL_W-1:0] tbl;
    logic [63:0] x, x2, t, s, d;
    tbl = '0;
    for (int j = 0; j <= QTR_STEPS; j++) begin
      x  = quot_work(HALF_PI_WORK * 64'(16 * j), TRIG_DEN);
      x2 = mul_work(x, x);
      t  = WORK_ONE;
      for (int n = SERIES_TERMS; n >= 1; n--) begin
        d = 64'((2 * n) * (2 * n + 1));
        t = WORK_ONE - quot_work(mul_work(x2, t), d);
      end
      s = mul_work(x, t);
      s = (s + WORK_HALF) >> (WORK_BITS - TRIG_FRAC_BITS);
      if (s > TRIG_ONE) begin
        s = TRIG_ONE;
      end
      tbl[j*TBL_W +: TBL_W] = s[TBL_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [(QTR_STEPS+1)*TBL_W-1:0] SIN_TBL = build_sin_tbl();

endpackage

// ===== design/chvg_front.sv =====
// Front end: accepts requests, reduces the angle, looks up sine and cosine, drops unused codes.
module chvg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [chvg_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  output logic                           push_o,
  output chvg_pkg::job_t                 push_job_o,
  input  logic                           full_i
);

  logic                                en;
  logic [1:0]                          op_w;
  logic [chvg_pkg::ANGLE_W-1:0]        ang_w, k_w;
  logic [chvg_pkg::LEN_W:0]            mid_sum_w;
  logic [1:0]                          quad_w;
  logic [chvg_pkg::QIDX_W-1:0]         j_w;

  logic                                v1_q;
  logic [1:0]                          op1_q, quad1_q;
  logic [chvg_pkg::QIDX_W-1:0]         j1_q;
  logic [chvg_pkg::LEN_W-1:0]          len1_q, off1_q, inner1_q, mid1_q;
  logic [chvg_pkg::WID_W-1:0]          wid1_q;

  logic [chvg_pkg::QIDX_W-1:0]         jc_w;
  logic [chvg_pkg::TBL_W-1:0]          tj_w, tjc_w, sin_mag_w, cos_mag_w;
  logic                                sin_neg_w, cos_neg_w;
  logic signed [chvg_pkg::TRIG_W-1:0]  sin_w, cos_w;

  logic                                v2_q;
  chvg_pkg::job_t                      job2_q;

  assign en              = !(v2_q && full_i);
  assign s_axis_tready_o = en;
  assign push_o          = v2_q && !full_i;
  assign push_job_o      = job2_q;

  assign op_w      = s_axis_tdata_i[1:0];
  assign ang_w     = s_axis_tdata_i[11:2];
  assign k_w       = (ang_w >= chvg_pkg::ANGLE_W'(chvg_pkg::ANGLE_STEPS)) ?
                     ang_w - chvg_pkg::ANGLE_W'(chvg_pkg::ANGLE_STEPS) : ang_w;
  assign mid_sum_w = {1'b0, s_axis_tdata_i[22:12]} + {1'b0, s_axis_tdata_i[41:31]};

  always_comb begin
    priority if (k_w >= chvg_pkg::ANGLE_W'(3 * chvg_pkg::QTR_STEPS)) begin
      quad_w = 2'd3;
      j_w    = chvg_pkg::QIDX_W'(k_w - chvg_pkg::ANGLE_W'(3 * chvg_pkg::QTR_STEPS));
    end else if (k_w >= chvg_pkg::ANGLE_W'(2 * chvg_pkg::QTR_STEPS)) begin
      quad_w = 2'd2;
      j_w    = chvg_pkg::QIDX_W'(k_w - chvg_pkg::ANGLE_W'(2 * chvg_pkg::QTR_STEPS));
    end else if (k_w >= chvg_pkg::ANGLE_W'(chvg_pkg::QTR_STEPS)) begin
      quad_w = 2'd1;
      j_w    = chvg_pkg::QIDX_W'(k_w - chvg_pkg::ANGLE_W'(chvg_pkg::QTR_STEPS));
    end else begin
      quad_w = 2'd0;
      j_w    = chvg_pkg::QIDX_W'(k_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      // shape code 3 produces nothing, so it never reaches the queue
      v1_q <= s_axis_tvalid_i && (op_w == chvg_pkg::OP_TICK || op_w == chvg_pkg::OP_TRI ||
                                  op_w == chvg_pkg::OP_DIAMOND);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q    <= op_w;
      quad1_q  <= quad_w;
      j1_q     <= j_w;
      len1_q   <= s_axis_tdata_i[22:12];
      wid1_q   <= s_axis_tdata_i[30:23];
      off1_q   <= s_axis_tdata_i[41:31];
      inner1_q <= s_axis_tdata_i[52:42];
      mid1_q   <= mid_sum_w[chvg_pkg::LEN_W:1];
    end
  end

  // quadrant folding: sin uses j or its mirror, cos the other one
  assign jc_w      = chvg_pkg::QIDX_W'(chvg_pkg::QTR_STEPS) - j1_q;
  assign tj_w      = chvg_pkg::SIN_TBL[j1_q*chvg_pkg::TBL_W +: chvg_pkg::TBL_W];
  assign tjc_w     = chvg_pkg::SIN_TBL[jc_w*chvg_pkg::TBL_W +: chvg_pkg::TBL_W];
  assign sin_mag_w = quad1_q[0] ? tjc_w : tj_w;
  assign cos_mag_w = quad1_q[0] ? tj_w : tjc_w;
  assign sin_neg_w = quad1_q[1];
  assign cos_neg_w = quad1_q[0] ^ quad1_q[1];
  assign sin_w     = sin_neg_w ? -$signed({1'b0, sin_mag_w}) : $signed({1'b0, sin_mag_w});
  assign cos_w     = cos_neg_w ? -$signed({1'b0, cos_mag_w}) : $signed({1'b0, cos_mag_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      job2_q.op    <= op1_q;
      job2_q.sin_v <= sin_w;
      job2_q.cos_v <= cos_w;
      job2_q.len   <= len1_q;
      job2_q.off   <= off1_q;
      job2_q.inner <= inner1_q;
      job2_q.mid   <= mid1_q;
      job2_q.wid   <= wid1_q;
    end
  end

endmodule

// ===== design/chvg_fifo.sv =====
// Short job queue between the front end and the vertex back end.
module chvg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  chvg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output chvg_pkg::job_t job_o
);

  chvg_pkg::job_t                 mem_q [chvg_pkg::QUEUE_DEPTH];
  logic [chvg_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [chvg_pkg::QCNT_W-1:0]    count_q;

  assign full_o  = (count_q == chvg_pkg::QCNT_W'(chvg_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == chvg_pkg::QPTR_W'(chvg_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == chvg_pkg::QPTR_W'(chvg_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/chvg_back.sv =====
// Back end: steps through the vertices of each job and computes them in a five-stage pipe.
module chvg_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  chvg_pkg::job_t                  job_i,
  output logic                            pop_o,
  input  logic [chvg_pkg::CTR_W-1:0]      center_x_i,
  input  logic [chvg_pkg::CTR_W-1:0]      center_y_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [chvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);

  typedef enum logic [2:0] {A_LEN, A_INNER, A_MID, A_OFF, A_WID} a_sel_e;

  // x = cx -/+ R(A*s +/- B*c), y = cy -/+ R(A*c +/- B*s)
  typedef struct packed {
    a_sel_e a_sel;
    logic   b_use;
    logic   kx_neg;
    logic   ky_neg;
    logic   x_neg;
    logic   y_neg;
    logic   trunc;
    logic   last;
  } vtx_ctl_t;

  function automatic vtx_ctl_t vtx_decode(input logic [1:0] op,
                                          input logic [chvg_pkg::VIDX_W-1:0] vidx);
    vtx_ctl_t ctl;
    ctl = '{a_sel: A_LEN, b_use: 1'b0, kx_neg: 1'b0, ky_neg: 1'b0,
            x_neg: 1'b0, y_neg: 1'b1, trunc: 1'b0, last: 1'b0};
    unique case (op)
      chvg_pkg::OP_TICK: begin
        ctl.trunc = 1'b1;
        if (vidx == '0) begin
          ctl.a_sel = A_INNER;
        end else begin
          ctl.last = 1'b1;
        end
      end
      chvg_pkg::OP_TRI: begin
        unique case (vidx)
          3'd1, 3'd2: begin
            ctl.a_sel  = A_WID;
            ctl.b_use  = 1'b1;
            ctl.ky_neg = 1'b1;
            ctl.x_neg  = 1'b1;
            ctl.y_neg  = 1'b0;
          end
          3'd3, 3'd4: begin
            ctl.a_sel  = A_WID;
            ctl.b_use  = 1'b1;
            ctl.kx_neg = 1'b1;
            ctl.x_neg  = 1'b1;
            ctl.y_neg  = 1'b0;
          end
          3'd5: ctl.last = 1'b1;
          default: ;
        endcase
      end
      chvg_pkg::OP_DIAMOND: begin
        unique case (vidx)
          3'd1: begin
            ctl.a_sel  = A_MID;
            ctl.b_use  = 1'b1;
            ctl.kx_neg = 1'b1;
          end
          3'd2: ctl.a_sel = A_OFF;
          3'd3: begin
            ctl.a_sel  = A_MID;
            ctl.b_use  = 1'b1;
            ctl.ky_neg = 1'b1;
          end
          3'd4: ctl.last = 1'b1;
          default: ;
        endcase
      end
      default: ctl.last = 1'b1;
    endcase
    return ctl;
  endfunction

  logic                              en;

  // sequencer
  chvg_pkg::job_t                    cur_q, cur_d;
  logic                              busy_q, busy_d;
  logic [chvg_pkg::VIDX_W-1:0]       vidx_q, vidx_d;
  vtx_ctl_t                          ctl_w;
  logic [chvg_pkg::LEN_W-1:0]        a_w;
  logic [chvg_pkg::WID_W-1:0]        b_w;

  // issue stage
  logic                              v0_q;
  vtx_ctl_t                          ctl0_q;
  logic [chvg_pkg::LEN_W-1:0]        a0_q;
  logic [chvg_pkg::WID_W-1:0]        b0_q;
  logic signed [chvg_pkg::TRIG_W-1:0] s0_q, c0_q;

  // product stage
  logic                              v1_q;
  vtx_ctl_t                          ctl1_q;
  logic signed [chvg_pkg::PROD_W-1:0] as_w, bc_w, ac_w, bs_w;
  logic signed [chvg_pkg::PROD_W-1:0] as1_q, bc1_q, ac1_q, bs1_q;

  // sum stage
  logic                              v2_q;
  vtx_ctl_t                          ctl2_q;
  logic signed [chvg_pkg::SUM_W-1:0] xs_w, ys_w, xs2_q, ys2_q;

  // rounding stage
  logic [chvg_pkg::SUM_W-1:0]        xmag_w, ymag_w, xrnd_w, yrnd_w, half_w;
  logic                              v3_q, last3_q, xneg3_q, yneg3_q;
  logic [chvg_pkg::MAG_W-1:0]        xr3_q, yr3_q;

  // output stage
  logic signed [chvg_pkg::COORD_W-1:0] xoff_w, yoff_w, px_w, py_w;
  logic                              out_valid_q, out_last_q;
  logic [chvg_pkg::PX_W-1:0]         out_x_q, out_y_q;

  assign en = !out_valid_q || m_axis_tready_i;

  assign ctl_w = vtx_decode(cur_q.op, vidx_q);

  always_comb begin
    unique case (ctl_w.a_sel)
      A_LEN:   a_w = cur_q.len;
      A_INNER: a_w = cur_q.inner;
      A_MID:   a_w = cur_q.mid;
      A_OFF:   a_w = cur_q.off;
      A_WID:   a_w = chvg_pkg::LEN_W'(cur_q.wid);
      default: a_w = cur_q.len;
    endcase
    b_w = ctl_w.b_use ? cur_q.wid : '0;
  end

  always_comb begin
    busy_d = busy_q;
    vidx_d = vidx_q;
    cur_d  = cur_q;
    pop_o  = 1'b0;
    if (en) begin
      if (busy_q) begin
        if (ctl_w.last) begin
          vidx_d = '0;
          // next job follows straight on when one is waiting
          if (job_valid_i) begin
            pop_o = 1'b1;
            cur_d = job_i;
          end else begin
            busy_d = 1'b0;
          end
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end else if (job_valid_i) begin
        pop_o  = 1'b1;
        cur_d  = job_i;
        busy_d = 1'b1;
        vidx_d = '0;
      end
    end
  end

  assign as_w = $signed({1'b0, a0_q}) * s0_q;
  assign ac_w = $signed({1'b0, a0_q}) * c0_q;
  assign bc_w = $signed({1'b0, b0_q}) * c0_q;
  assign bs_w = $signed({1'b0, b0_q}) * s0_q;

  assign xs_w = ctl1_q.kx_neg ? as1_q - bc1_q : as1_q + bc1_q;
  assign ys_w = ctl1_q.ky_neg ? ac1_q - bs1_q : ac1_q + bs1_q;

  assign half_w = ctl2_q.trunc ? '0 : chvg_pkg::SUM_W'(1) << (chvg_pkg::TRIG_FRAC_BITS - 1);
  assign xmag_w = xs2_q[chvg_pkg::SUM_W-1] ? -xs2_q : xs2_q;
  assign ymag_w = ys2_q[chvg_pkg::SUM_W-1] ? -ys2_q : ys2_q;
  assign xrnd_w = xmag_w + half_w;
  assign yrnd_w = ymag_w + half_w;

  assign xoff_w = xneg3_q ? -$signed({1'b0, xr3_q}) : $signed({1'b0, xr3_q});
  assign yoff_w = yneg3_q ? -$signed({1'b0, yr3_q}) : $signed({1'b0, yr3_q});
  assign px_w   = $signed({{(chvg_pkg::COORD_W-chvg_pkg::CTR_W){1'b0}}, center_x_i}) + xoff_w;
  assign py_w   = $signed({{(chvg_pkg::COORD_W-chvg_pkg::CTR_W){1'b0}}, center_y_i}) + yoff_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      vidx_q      <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      vidx_q <= vidx_d;
      if (en) begin
        v0_q        <= busy_q;
        v1_q        <= v0_q;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (en) begin
      ctl0_q  <= ctl_w;
      a0_q    <= a_w;
      b0_q    <= b_w;
      s0_q    <= cur_q.sin_v;
      c0_q    <= cur_q.cos_v;

      ctl1_q  <= ctl0_q;
      as1_q   <= as_w;
      bc1_q   <= bc_w;
      ac1_q   <= ac_w;
      bs1_q   <= bs_w;

      ctl2_q  <= ctl1_q;
      xs2_q   <= xs_w;
      ys2_q   <= ys_w;

      last3_q <= ctl2_q.last;
      xneg3_q <= xs2_q[chvg_pkg::SUM_W-1] ^ ctl2_q.x_neg;
      yneg3_q <= ys2_q[chvg_pkg::SUM_W-1] ^ ctl2_q.y_neg;
      xr3_q   <= xrnd_w[chvg_pkg::SUM_W-1:chvg_pkg::TRIG_FRAC_BITS];
      yr3_q   <= yrnd_w[chvg_pkg::SUM_W-1:chvg_pkg::TRIG_FRAC_BITS];

      out_last_q <= last3_q;
      out_x_q    <= px_w[chvg_pkg::PX_W-1:0];
      out_y_q    <= py_w[chvg_pkg::PX_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(chvg_pkg::OUT_DATA_W-2*chvg_pkg::PX_W){1'b0}}, out_y_q, out_x_q};

endmodule

// ===== design/clock_hand_vertex_generator_unit.sv =====
// Top level of the clock hand vertex generator: centre registers, front end, queue, back end.
// Throughput: one vertex per cycle while the output is not stalled; a request gives 2 (tick),
// 5 (diamond) or 6 (triangle) vertices, set by the back-end vertex sequencer; the front end takes
// a request every cycle while the two-entry queue has room. Shape code 3 is dropped without output.
// Reset (asynchronous, active low) empties all pipes and the queue and clears the centre to 0.
module clock_hand_vertex_generator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: opcode[1:0], angle_index[11:2], hand_length[22:12], half_width[30:23],
  //        tail_offset[41:31], inner_length[52:42], zero fill above
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [chvg_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tdata: point_x[12:0], point_y[25:13], zero fill above; tlast: last_point
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [chvg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_we_i,
  input  logic [chvg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [chvg_pkg::CTR_W-1:0]         cfg_data_i
);

  logic [chvg_pkg::CTR_W-1:0] center_x_q, center_y_q;
  logic                       push, full, pop, job_valid;
  chvg_pkg::job_t             push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        chvg_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
        chvg_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  chvg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .push_job_o      (push_job),
    .full_i          (full)
  );

  chvg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  chvg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .center_x_i      (center_x_q),
    .center_y_i      (center_y_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== design/chvg_checker.sv =====
// Port-level checks on the clock hand vertex generator, bound to the top level.
module chvg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [chvg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [chvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o,
  input logic                            cfg_we_i,
  input logic [chvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [chvg_pkg::CTR_W-1:0]      cfg_data_i
);

  // a stalled vertex stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  // fill bits above the two coordinates are always zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[chvg_pkg::OUT_DATA_W-1:2*chvg_pkg::PX_W] == '0)
    else $error("nonzero fill bits in output tdata");

  // no vertex shows during reset or on the first edge after it
  assert property (@(posedge clk_i) !rst_ni || $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid around reset");

endmodule

bind clock_hand_vertex_generator_unit chvg_checker u_chvg_checker (.*);
